@@ sv/rri_pkg.sv @@
package rri_pkg;

    localparam int IDX_W = 4;

    typedef enum logic [IDX_W-1:0] {
        REG_CENTER_X     = 4'd0,
        REG_CENTER_Y     = 4'd1,
        REG_CENTER_Z     = 4'd2,
        REG_NORMAL_X     = 4'd3,
        REG_NORMAL_Y     = 4'd4,
        REG_NORMAL_Z     = 4'd5,
        REG_INNER_RADIUS = 4'd6,
        REG_OUTER_RADIUS = 4'd7
    } rri_reg_t;

endpackage

@@ sv/rri_ray_if.sv @@
interface rri_ray_if #(parameter int COORD_WIDTH = 32);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] ray_org_x;
    logic signed [COORD_WIDTH-1:0] ray_org_y;
    logic signed [COORD_WIDTH-1:0] ray_org_z;
    logic signed [COORD_WIDTH-1:0] ray_dir_x;
    logic signed [COORD_WIDTH-1:0] ray_dir_y;
    logic signed [COORD_WIDTH-1:0] ray_dir_z;

    modport source (output valid, ray_org_x, ray_org_y, ray_org_z,
                    ray_dir_x, ray_dir_y, ray_dir_z, input ready);
    modport sink (input valid, ray_org_x, ray_org_y, ray_org_z,
                  ray_dir_x, ray_dir_y, ray_dir_z, output ready);
endinterface

@@ sv/rri_res_if.sv @@
interface rri_res_if #(parameter int COORD_WIDTH = 32);
    logic                   valid;
    logic                   ready;
    logic                   hit;
    logic [COORD_WIDTH-2:0] hit_distance;

    modport source (output valid, hit, hit_distance, input ready);
    modport sink (input valid, hit, hit_distance, output ready);
endinterface

@@ sv/rri_cfg_if.sv @@
interface rri_cfg_if #(parameter int COORD_WIDTH = 32);
    logic                      valid;
    logic                      ready;
    logic [rri_pkg::IDX_W-1:0] index;
    logic [COORD_WIDTH-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

@@ sv/ray_ring_intersect_top.sv @@
// Ray against flat ring test. One ray is accepted per cycle while the pipeline
// is not stalled, and each ray gives exactly one result beat, in order: the
// first stages form the plane dot products, the restoring divider then finds t
// (one quotient bit per stage after the first, which detects saturation), and
// the last stages form and test the hit point. Every stage holds
// only while the stage after it is full and stalled, so bubbles collapse.
// Configuration writes are taken at any time but must only be issued while
// the pipeline is empty.
module ray_ring_intersect_top #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic   clk,
    input  logic   rst_n,
    rri_cfg_if.sink   cfg,
    rri_ray_if.sink   ray,
    rri_res_if.source res
);
    import rri_pkg::*;

    localparam int W   = COORD_WIDTH;
    localparam int F   = FRAC_BITS;
    localparam int XW  = 3 * W + F + 3;
    localparam int DIV = 4;
    localparam int SP  = DIV + W;
    localparam int SQ  = SP + 1;
    localparam int SR  = SQ + 1;
    localparam int SO  = SR + 1;
    localparam int NST = SO + 1;

    typedef struct packed {
        logic [XW-1:0]        rem;
        logic [2*W+1:0]       dabs;
        logic                 miss;
        logic                 sat;
        logic [W-2:0]         quo;
        logic [2:0][W:0]      dco;
        logic [2:0][W-1:0]    dir;
    } div_t;

    // configuration
    logic signed [W-1:0] center_reg [3];
    logic signed [W-1:0] normal_reg [3];
    logic [W-2:0]        inner_radius_reg;
    logic [W-2:0]        outer_radius_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_reg[0]    <= '0;
            center_reg[1]    <= '0;
            center_reg[2]    <= '0;
            normal_reg[0]    <= '0;
            normal_reg[1]    <= '0;
            normal_reg[2]    <= W'(1) << F;
            inner_radius_reg <= '0;
            outer_radius_reg <= (W-1)'(1) << F;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_CENTER_X:     center_reg[0] <= cfg.data;
                REG_CENTER_Y:     center_reg[1] <= cfg.data;
                REG_CENTER_Z:     center_reg[2] <= cfg.data;
                REG_NORMAL_X:     normal_reg[0] <= cfg.data;
                REG_NORMAL_Y:     normal_reg[1] <= cfg.data;
                REG_NORMAL_Z:     normal_reg[2] <= cfg.data;
                REG_INNER_RADIUS: inner_radius_reg <= cfg.data[W-2:0];
                REG_OUTER_RADIUS: outer_radius_reg <= cfg.data[W-2:0];
                default:          ;
            endcase
        end
    end

    // stage control
    logic [NST-1:0] vld_reg;
    logic [NST-1:0] en;

    always_comb
    begin
        en[NST-1] = !vld_reg[NST-1] || res.ready;
        for (int k = NST - 2; k >= 0; k--)
            en[k] = !vld_reg[k] || en[k+1];
    end

    assign ray.ready = en[0];
    assign res.valid = vld_reg[NST-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
        begin
            if (en[0])
                vld_reg[0] <= ray.valid;
            for (int k = 1; k < NST; k++)
                if (en[k])
                    vld_reg[k] <= vld_reg[k-1];
        end
    end

    // stage 1: c - o
    logic signed [W-1:0] org [3];
    logic signed [W-1:0] dir [3];
    assign org[0] = ray.ray_org_x;
    assign org[1] = ray.ray_org_y;
    assign org[2] = ray.ray_org_z;
    assign dir[0] = ray.ray_dir_x;
    assign dir[1] = ray.ray_dir_y;
    assign dir[2] = ray.ray_dir_z;

    logic signed [W:0]   dco1_reg [3];
    logic signed [W-1:0] dir1_reg [3];

    always_ff @(posedge clk)
    begin
        if (en[0])
            for (int i = 0; i < 3; i++)
            begin
                dco1_reg[i] <= {center_reg[i][W-1], center_reg[i]} - {org[i][W-1], org[i]};
                dir1_reg[i] <= dir[i];
            end
    end

    // stage 2: products
    logic signed [2*W:0]   pn2_reg  [3];
    logic signed [2*W-1:0] pd2_reg  [3];
    logic signed [W:0]     dco2_reg [3];
    logic signed [W-1:0]   dir2_reg [3];

    always_ff @(posedge clk)
    begin
        if (en[1])
            for (int i = 0; i < 3; i++)
            begin
                pn2_reg[i]  <= normal_reg[i] * dco1_reg[i];
                pd2_reg[i]  <= normal_reg[i] * dir1_reg[i];
                dco2_reg[i] <= dco1_reg[i];
                dir2_reg[i] <= dir1_reg[i];
            end
    end

    // stage 3: dot products
    logic signed [2*W+2:0] num3_reg;
    logic signed [2*W+1:0] den3_reg;
    logic signed [W:0]     dco3_reg [3];
    logic signed [W-1:0]   dir3_reg [3];

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            num3_reg <= {{2{pn2_reg[0][2*W]}}, pn2_reg[0]}
                      + {{2{pn2_reg[1][2*W]}}, pn2_reg[1]}
                      + {{2{pn2_reg[2][2*W]}}, pn2_reg[2]};
            den3_reg <= {{2{pd2_reg[0][2*W-1]}}, pd2_reg[0]}
                      + {{2{pd2_reg[1][2*W-1]}}, pd2_reg[1]}
                      + {{2{pd2_reg[2][2*W-1]}}, pd2_reg[2]};
            for (int i = 0; i < 3; i++)
            begin
                dco3_reg[i] <= dco2_reg[i];
                dir3_reg[i] <= dir2_reg[i];
            end
        end
    end

    // stage 4: magnitudes and early misses
    logic [2*W+2:0] nabs_next;
    logic [2*W+1:0] dabs_next;
    logic           miss_next;

    always_comb
    begin
        nabs_next = num3_reg[2*W+2] ? (2*W+3)'(-num3_reg) : (2*W+3)'(num3_reg);
        dabs_next = den3_reg[2*W+1] ? (2*W+2)'(-den3_reg) : (2*W+2)'(den3_reg);
        miss_next = (den3_reg == '0)
                 || ((num3_reg != '0) && (num3_reg[2*W+2] != den3_reg[2*W+1]));
    end

    logic [XW-1:0]       rem4_reg;
    logic [2*W+1:0]      dabs4_reg;
    logic                miss4_reg;
    logic [2:0][W:0]     dco4_reg;
    logic [2:0][W-1:0]   dir4_reg;

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            rem4_reg  <= XW'(nabs_next) << F;
            dabs4_reg <= dabs_next;
            miss4_reg <= miss_next;
            for (int i = 0; i < 3; i++)
            begin
                dco4_reg[i] <= dco3_reg[i];
                dir4_reg[i] <= dir3_reg[i];
            end
        end
    end

    // divider: first stage flags t beyond the field, then one quotient bit per stage
    div_t div_reg  [W];
    div_t div_next [W];

    always_comb
    begin
        div_next[0].rem  = rem4_reg;
        div_next[0].dabs = dabs4_reg;
        div_next[0].miss = miss4_reg;
        div_next[0].sat  = rem4_reg >= (XW'(dabs4_reg) << (W - 1));
        div_next[0].quo  = '0;
        div_next[0].dco  = dco4_reg;
        div_next[0].dir  = dir4_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en[DIV])
            div_reg[0] <= div_next[0];
    end

    for (genvar k = 1; k < W; k++)
    begin : g_div
        localparam int B = W - 1 - k;
        logic [XW-1:0] dsh;
        logic          ge;

        always_comb
        begin
            dsh         = XW'(div_reg[k-1].dabs) << B;
            ge          = div_reg[k-1].rem >= dsh;
            div_next[k] = div_reg[k-1];
            if (ge)
            begin
                div_next[k].rem    = div_reg[k-1].rem - dsh;
                div_next[k].quo[B] = 1'b1;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en[DIV+k])
                div_reg[k] <= div_next[k];
        end
    end

    // stage P: t * dir
    logic [W-2:0]        tq_next;
    logic signed [W-1:0] tqs;
    assign tq_next = div_reg[W-1].sat ? '1 : div_reg[W-1].quo;
    assign tqs     = $signed({1'b0, tq_next});

    logic signed [2*W-1:0] prodp_reg [3];
    logic signed [W:0]     dcop_reg  [3];
    logic [W-2:0]          tqp_reg;
    logic                  missp_reg;

    always_ff @(posedge clk)
    begin
        if (en[SP])
        begin
            for (int i = 0; i < 3; i++)
            begin
                prodp_reg[i] <= tqs * $signed(div_reg[W-1].dir[i]);
                dcop_reg[i]  <= $signed(div_reg[W-1].dco[i]);
            end
            tqp_reg   <= tq_next;
            missp_reg <= div_reg[W-1].miss;
        end
    end

    // stage Q: hit point relative to center, far check
    logic signed [2*W:0] qq   [3];
    logic [2*W:0]        qabs [3];
    logic                far_next;

    always_comb
    begin
        far_next = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            qq[i]   = ($signed({prodp_reg[i][2*W-1], prodp_reg[i]}) >>> F)
                    - $signed({{W{dcop_reg[i][W]}}, dcop_reg[i]});
            qabs[i] = qq[i][2*W] ? (2*W+1)'(-qq[i]) : (2*W+1)'(qq[i]);
            if (qabs[i][2*W:W-1] != '0)
                far_next = 1'b1;
        end
    end

    logic [W-2:0] qa_reg [3];
    logic [W-2:0] tqq_reg;
    logic         missq_reg;

    always_ff @(posedge clk)
    begin
        if (en[SQ])
        begin
            for (int i = 0; i < 3; i++)
                qa_reg[i] <= qabs[i][W-2:0];
            tqq_reg   <= tqp_reg;
            missq_reg <= missp_reg || far_next;
        end
    end

    // stage R: squares
    logic [2*W-3:0] sq_reg [3];
    logic [2*W-3:0] ri2_reg;
    logic [2*W-3:0] ro2_reg;
    logic [W-2:0]   tqr_reg;
    logic           missr_reg;

    always_ff @(posedge clk)
    begin
        if (en[SR])
        begin
            for (int i = 0; i < 3; i++)
                sq_reg[i] <= qa_reg[i] * qa_reg[i];
            ri2_reg   <= inner_radius_reg * inner_radius_reg;
            ro2_reg   <= outer_radius_reg * outer_radius_reg;
            tqr_reg   <= tqq_reg;
            missr_reg <= missq_reg;
        end
    end

    // output register
    logic [2*W-1:0] dist_next;
    logic           hit_next;
    logic           hit_reg;
    logic [W-2:0]   hit_distance_reg;

    always_comb
    begin
        dist_next = (2*W)'(sq_reg[0]) + (2*W)'(sq_reg[1]) + (2*W)'(sq_reg[2]);
        hit_next  = !missr_reg && (dist_next > (2*W)'(ri2_reg))
                 && (dist_next < (2*W)'(ro2_reg));
    end

    always_ff @(posedge clk)
    begin
        if (en[SO])
        begin
            hit_reg          <= hit_next;
            hit_distance_reg <= hit_next ? tqr_reg : '0;
        end
    end

    assign res.hit          = hit_reg;
    assign res.hit_distance = hit_distance_reg;

`ifndef SYNTHESIS
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && !res.hit |-> res.hit_distance == '0)
        else $error("miss beat carries nonzero distance");

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        !ray.ready |-> (vld_reg == '1) && !res.ready)
        else $error("input stalled with a bubble in the pipeline");

    a_hit_radii: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.hit |-> inner_radius_reg < outer_radius_reg)
        else $error("hit reported with crossed radii");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[SR] && en[SO] |=> res.valid)
        else $error("result beat lost at output register");
`endif

endmodule
